### src/pds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Shared widths, register indexes and word types of the position deadband
// smoother.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int SQ_W        = 2 * COORD_WIDTH;
  localparam int DIST_W      = SQ_W + 2;
  localparam int THR_W       = 23;
  localparam int GAIN_W      = 17;
  localparam int GAIN_FRAC   = 16;
  localparam int PROD_W      = GAIN_W + 1 + DIFF_W;
  localparam int CMP_W       = (DIST_W > 2 * THR_W) ? DIST_W : 2 * THR_W;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND = 2'd0,
    REG_GAIN     = 2'd1
  } cfg_reg_e;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic                          sample_finite;
  } sample_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          held;
  } result_t;

  typedef struct packed {
    logic   have_previous;
    coord_t previous_x;
    coord_t previous_y;
    coord_t previous_z;
  } state_t;

  typedef struct packed {
    logic [THR_W-1:0]  deadband_threshold;
    logic [GAIN_W-1:0] smoothing_gain;
  } cfg_t;

endpackage

### src/pds_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_in_if
// Sample channel: valid/ready handshake with one position sample per word.
// ----------------------------------------------------------------------------
interface pds_in_if;
  logic             valid;
  logic             ready;
  pds_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/pds_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_out_if
// Result channel: valid/ready handshake with one filtered position per word.
// ----------------------------------------------------------------------------
interface pds_out_if;
  logic             valid;
  logic             ready;
  pds_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/pds_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pds_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pds_pkg::CFG_IDX_W-1:0]    index;
  logic [pds_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/pds_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_cfg_regs
// Deadband threshold and smoothing gain registers behind the write channel.
// ----------------------------------------------------------------------------
module pds_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  pds_cfg_if.sink        cfg_if,
  output pds_pkg::cfg_t  cfg_o
);

  logic [pds_pkg::THR_W-1:0]  thr_q, thr_d;
  logic [pds_pkg::GAIN_W-1:0] gain_q, gain_d;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    thr_d  = thr_q;
    gain_d = gain_q;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        pds_pkg::REG_DEADBAND: thr_d  = cfg_if.data[pds_pkg::THR_W-1:0];
        pds_pkg::REG_GAIN:     gain_d = cfg_if.data[pds_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      gain_q <= pds_pkg::GAIN_ONE;
    end else begin
      thr_q  <= thr_d;
      gain_q <= gain_d;
    end
  end

  assign cfg_o.deadband_threshold = thr_q;
  assign cfg_o.smoothing_gain     = gain_q;

endmodule

### src/pds_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_filter
// One filter step: deadband test against the stored position, smoothing
// toward the sample, and the next stored position.
// ----------------------------------------------------------------------------
module pds_filter (
  input  pds_pkg::sample_t sample_i,
  input  pds_pkg::state_t  state_i,
  input  pds_pkg::cfg_t    cfg_i,
  output pds_pkg::result_t result_o,
  output pds_pkg::state_t  state_o
);

  localparam int CW = pds_pkg::COORD_WIDTH;

  logic signed [pds_pkg::DIFF_W-1:0]   dx, dy, dz;
  logic signed [2*pds_pkg::DIFF_W-1:0] px2, py2, pz2;
  logic [pds_pkg::CMP_W-1:0]           dist2, thr2;
  logic signed [pds_pkg::PROD_W-1:0]   mx, my, mz;
  logic signed [pds_pkg::PROD_W-1:0]   sx, sy, sz;
  logic signed [pds_pkg::GAIN_W:0]     alpha;
  pds_pkg::coord_t                     nx, ny, nz;
  logic                                use_db, use_sm;

  always_comb begin
    dx = {sample_i.pos_x[CW-1], sample_i.pos_x} - {state_i.previous_x[CW-1], state_i.previous_x};
    dy = {sample_i.pos_y[CW-1], sample_i.pos_y} - {state_i.previous_y[CW-1], state_i.previous_y};
    dz = {sample_i.pos_z[CW-1], sample_i.pos_z} - {state_i.previous_z[CW-1], state_i.previous_z};

    px2 = dx * dx;
    py2 = dy * dy;
    pz2 = dz * dz;
    dist2 = pds_pkg::CMP_W'(px2[pds_pkg::SQ_W-1:0])
          + pds_pkg::CMP_W'(py2[pds_pkg::SQ_W-1:0])
          + pds_pkg::CMP_W'(pz2[pds_pkg::SQ_W-1:0]);
    thr2  = pds_pkg::CMP_W'(cfg_i.deadband_threshold) * pds_pkg::CMP_W'(cfg_i.deadband_threshold);

    alpha = $signed({1'b0, cfg_i.smoothing_gain});
    mx = pds_pkg::PROD_W'(alpha) * pds_pkg::PROD_W'(dx);
    my = pds_pkg::PROD_W'(alpha) * pds_pkg::PROD_W'(dy);
    mz = pds_pkg::PROD_W'(alpha) * pds_pkg::PROD_W'(dz);
    sx = mx >>> pds_pkg::GAIN_FRAC;
    sy = my >>> pds_pkg::GAIN_FRAC;
    sz = mz >>> pds_pkg::GAIN_FRAC;
    nx = state_i.previous_x + sx[CW-1:0];
    ny = state_i.previous_y + sy[CW-1:0];
    nz = state_i.previous_z + sz[CW-1:0];

    use_db = (cfg_i.deadband_threshold != '0);
    use_sm = (cfg_i.smoothing_gain != '0) && (cfg_i.smoothing_gain < pds_pkg::GAIN_ONE);

    result_o.out_x = sample_i.pos_x;
    result_o.out_y = sample_i.pos_y;
    result_o.out_z = sample_i.pos_z;
    result_o.held  = 1'b0;
    state_o        = state_i;

    if ((!use_db && !use_sm) || !sample_i.sample_finite) begin
      state_o = '0;
    end else if (!state_i.have_previous) begin
      state_o.have_previous = 1'b1;
      state_o.previous_x    = sample_i.pos_x;
      state_o.previous_y    = sample_i.pos_y;
      state_o.previous_z    = sample_i.pos_z;
    end else if (use_db && (dist2 <= thr2)) begin
      result_o.out_x = state_i.previous_x;
      result_o.out_y = state_i.previous_y;
      result_o.out_z = state_i.previous_z;
      result_o.held  = 1'b1;
    end else begin
      if (use_sm) begin
        result_o.out_x = nx;
        result_o.out_y = ny;
        result_o.out_z = nz;
      end
      state_o.have_previous = 1'b1;
      state_o.previous_x    = result_o.out_x;
      state_o.previous_y    = result_o.out_y;
      state_o.previous_z    = result_o.out_z;
    end
  end

endmodule

### src/position_deadband_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_deadband_smoother
// 3D position deadband and exponential smoothing filter, Q8.16 metres.
// ----------------------------------------------------------------------------
// Accepts one sample word per cycle while the output side is not stalled and
// returns one result word per sample. A sample is captured in an input
// register, filtered in one combinational pass (differences, squared
// distance compare, gain multiply) that also updates the stored position,
// and lands in the result register; the stored-position feedback around
// that single pass sets the one-word-per-cycle rate.
// Configuration writes take effect at once and must only be issued while the
// block is idle.
module position_deadband_smoother (
  input  logic      clk_i,
  input  logic      rst_ni,
  pds_in_if.sink    in_if,
  pds_out_if.source out_if,
  pds_cfg_if.sink   cfg_if
);

  pds_pkg::cfg_t    cfg;
  pds_pkg::sample_t sample_q;
  logic             s1_valid_q, s1_valid_d;
  pds_pkg::result_t result_q, result_d;
  logic             out_valid_q, out_valid_d;
  pds_pkg::state_t  state_q, state_d, state_next;
  logic             advance;

  pds_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  pds_filter u_filter (
    .sample_i (sample_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .result_o (result_d),
    .state_o  (state_next)
  );

  assign advance     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || advance;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    state_d     = state_q;
    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      state_d     = state_next;
      s1_valid_d  = 1'b0;
    end
    if (in_if.valid && in_if.ready) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      sample_q <= in_if.data;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = result_q;

endmodule
